FILE: rtl/sra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sra_pkg;

	localparam int MAX_SHELVES = 64;
	localparam int IDX_W       = $clog2(MAX_SHELVES);
	localparam int CNT_W       = $clog2(MAX_SHELVES + 1);
	localparam int DIM_W       = 13;
	localparam int POS_W       = 12;
	localparam int PAD_W       = 4;
	localparam int PDIM_W      = DIM_W + 1;
	localparam int REG_IDX_W   = 2;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_ATLAS_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ATLAS_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_PAD_AMOUNT   = 2'd2;

	localparam logic [DIM_W-1:0] ATLAS_WIDTH_RST  = 13'd1024;
	localparam logic [DIM_W-1:0] ATLAS_HEIGHT_RST = 13'd1024;
	localparam logic [PAD_W-1:0] PAD_AMOUNT_RST   = 4'd1;

	typedef struct packed {
		logic [DIM_W-1:0] rect_width;
		logic [DIM_W-1:0] rect_height;
	} sra_req_t;

	typedef struct packed {
		logic             placed;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic             opened_shelf;
	} sra_res_t;

	typedef struct packed {
		logic [DIM_W-1:0] top;
		logic [DIM_W-1:0] span;
		logic [DIM_W-1:0] cursor;
	} sra_entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		sra_entry_t       entry;
	} sra_wr_t;

	typedef struct packed {
		logic             fit;
		logic [DIM_W-1:0] next_cursor;
		sra_entry_t       entry;
	} sra_fit_t;

endpackage

`default_nettype wire

FILE: rtl/sra_shelf_table.sv
`timescale 1ns / 1ps
`default_nettype none

module sra_shelf_table import sra_pkg::*; (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [IDX_W-1:0]  rd_addr,
	input  wire sra_wr_t           wr,
	input  wire logic [DIM_W-1:0]  rect_height,
	input  wire logic [PDIM_W-1:0] pad_width,
	input  wire logic [DIM_W-1:0]  atlas_width,
	output sra_fit_t               fit
);

	sra_entry_t                mem [MAX_SHELVES];
	sra_entry_t                rd_data_s1;
	logic [PDIM_W:0]           end_col;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// test the entry just read against the pending rectangle
	assign end_col = {2'b00, rd_data_s1.cursor} + {1'b0, pad_width};

	always_comb begin
		fit.entry       = rd_data_s1;
		fit.next_cursor = end_col[DIM_W-1:0];
		fit.fit         = (rect_height <= rd_data_s1.span) &&
		                  (end_col <= {2'b00, atlas_width});
	end

endmodule

`default_nettype wire

FILE: rtl/shelf_rect_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                           Handshake
// --------  ------------------------------  ---------------------------------------
// request   start, busy, req                word taken when start high, busy low
// result    done, res                       word valid for the one cycle done is high
// config    cfg_we, cfg_index, cfg_data     register written when cfg_we is high
//
// An item walks the open shelves in order (at most MAX_SHELVES of them) before the done
// strobe; when the table is empty it goes straight to opening a shelf, and a hit on a
// shelf ends the walk.
// The walk is set by the single read port of the shelf table, one entry a cycle, with
// the read data registered in the table.
// Reset clears the shelf count and loads the register defaults; table contents stay
// undefined and are never read beyond the count. The result side cannot stall.

module shelf_rect_allocator import sra_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire sra_req_t             req,
	output logic                      done,
	output sra_res_t                  res,
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_OPEN = 3'b100
	} state_t;

	state_t              state_q;
	logic [DIM_W-1:0]    atlas_width_q;
	logic [DIM_W-1:0]    atlas_height_q;
	logic [PAD_W-1:0]    pad_amount_q;

	logic [CNT_W-1:0]    count_q;
	logic [DIM_W-1:0]    last_top_q;
	logic [DIM_W-1:0]    last_span_q;

	logic [DIM_W-1:0]    height_q;
	logic [PDIM_W-1:0]   pad_w_q;
	logic [PDIM_W-1:0]   pad_h_q;

	logic [CNT_W-1:0]    rd_idx_q;
	logic                rd_vld_s1;
	logic [CNT_W-1:0]    cmp_idx_s1;

	logic                done_q;
	sra_res_t            res_q;

	logic                accept;
	logic                rd_en;
	logic                hit;
	logic                last_cmp;
	sra_fit_t            fit;
	sra_wr_t             wr;

	logic [PDIM_W:0]     new_top;
	logic [PDIM_W+1:0]   new_bottom;
	logic                open_ok;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign res    = res_q;

	// issue one read a cycle while shelves remain to be walked
	assign rd_en    = (state_q == ST_SCAN) && (rd_idx_q < count_q);
	assign hit      = (state_q == ST_SCAN) && rd_vld_s1 && fit.fit;
	assign last_cmp = rd_vld_s1 && ((cmp_idx_s1 + CNT_W'(1)) == count_q);

	// a new shelf sits one padding below the bottom of the last shelf
	always_comb begin
		if (count_q == '0) begin
			new_top = '0;
		end else begin
			new_top = {2'b00, last_top_q} + {2'b00, last_span_q} +
			          {{(PDIM_W+1-PAD_W){1'b0}}, pad_amount_q};
		end
		new_bottom = {1'b0, new_top} + {2'b00, pad_h_q};
		open_ok    = (count_q < CNT_W'(MAX_SHELVES)) &&
		             (new_bottom <= {3'b000, atlas_height_q}) &&
		             (pad_w_q <= {1'b0, atlas_width_q});
	end

	// write back the advanced cursor on a hit, or the fresh entry when a shelf opens
	always_comb begin
		wr = '0;
		if (hit) begin
			wr.en           = 1'b1;
			wr.addr         = cmp_idx_s1[IDX_W-1:0];
			wr.entry        = fit.entry;
			wr.entry.cursor = fit.next_cursor;
		end else if (state_q == ST_OPEN && open_ok) begin
			wr.en           = 1'b1;
			wr.addr         = count_q[IDX_W-1:0];
			wr.entry.top    = new_top[DIM_W-1:0];
			wr.entry.span   = pad_h_q[DIM_W-1:0];
			wr.entry.cursor = pad_w_q[DIM_W-1:0];
		end
	end

	sra_shelf_table u_table (
		.clk         (clk),
		.rd_en       (rd_en),
		.rd_addr     (rd_idx_q[IDX_W-1:0]),
		.wr          (wr),
		.rect_height (height_q),
		.pad_width   (pad_w_q),
		.atlas_width (atlas_width_q),
		.fit         (fit)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_width_q  <= ATLAS_WIDTH_RST;
			atlas_height_q <= ATLAS_HEIGHT_RST;
			pad_amount_q   <= PAD_AMOUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ATLAS_WIDTH:  atlas_width_q  <= cfg_data;
				REG_ATLAS_HEIGHT: atlas_height_q <= cfg_data;
				REG_PAD_AMOUNT:   pad_amount_q   <= cfg_data[PAD_W-1:0];
				default: ;
			endcase
		end
	end

	// hold the padded request for the whole walk
	always_ff @(posedge clk) begin
		if (accept) begin
			height_q <= req.rect_height;
			pad_w_q  <= {1'b0, req.rect_width} + {{(PDIM_W-PAD_W){1'b0}}, pad_amount_q};
			pad_h_q  <= {1'b0, req.rect_height} + {{(PDIM_W-PAD_W){1'b0}}, pad_amount_q};
		end
	end

	// last shelf geometry, valid whenever the count is non-zero
	always_ff @(posedge clk) begin
		if (state_q == ST_OPEN && open_ok) begin
			last_top_q  <= new_top[DIM_W-1:0];
			last_span_q <= pad_h_q[DIM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			rd_idx_q   <= '0;
			rd_vld_s1  <= 1'b0;
			cmp_idx_s1 <= '0;
			done_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					done_q    <= 1'b0;
					rd_idx_q  <= '0;
					rd_vld_s1 <= 1'b0;
					if (accept) begin
						state_q <= (count_q == '0) ? ST_OPEN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					// drop the read still in flight on a hit
					rd_vld_s1  <= rd_en && !hit;
					cmp_idx_s1 <= rd_idx_q;
					done_q     <= hit;
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (hit) begin
						state_q <= ST_IDLE;
					end else if (last_cmp) begin
						state_q <= ST_OPEN;
					end
				end
				ST_OPEN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
					if (open_ok) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				default: begin
					done_q    <= 1'b0;
					state_q   <= ST_IDLE;
					rd_vld_s1 <= 1'b0;
				end
			endcase
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (hit) begin
			res_q.placed       <= 1'b1;
			res_q.pos_x        <= fit.entry.cursor[POS_W-1:0];
			res_q.pos_y        <= fit.entry.top[POS_W-1:0];
			res_q.opened_shelf <= 1'b0;
		end else if (state_q == ST_OPEN) begin
			res_q.placed       <= open_ok;
			res_q.pos_x        <= '0;
			res_q.pos_y        <= open_ok ? new_top[POS_W-1:0] : '0;
			res_q.opened_shelf <= open_ok;
		end
	end

endmodule

`default_nettype wire
